// ----- sv/imusfd_pkg.sv -----
// Shared types, constants and scaling helpers of the serial IMU frame decoder.
package imusfd_pkg;

	localparam int MAX_FRAMES  = 4;
	localparam int FRAME_BYTES = 11;
	localparam int SLOT_W      = $clog2(MAX_FRAMES + 1);
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 128;

	localparam logic [7:0] HEAD_RESET    = 8'h55;
	localparam logic [7:0] MIN_LEN_RESET = 8'd33;

	localparam logic [7:0] TYPE_ACC   = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_QUAT  = 8'h59;

	// doubled scale: v*S/32768 in Q15.16 is v*2*S
	localparam logic [11:0] SCALE2_ACC   = 12'd32;
	localparam logic [11:0] SCALE2_RATE  = 12'd4000;
	localparam logic [11:0] SCALE2_ANGLE = 12'd360;
	localparam logic [11:0] SCALE2_QUAT  = 12'd2;

	localparam logic REG_HEAD_BYTE  = 1'b0;
	localparam logic REG_MIN_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACC   = 2'd0,
		KIND_RATE  = 2'd1,
		KIND_ANGLE = 2'd2,
		KIND_QUAT  = 2'd3
	} kind_t;

	typedef struct packed {
		logic  known;
		kind_t kind;
	} type_dec_t;

	// one decoded slot waiting for scaling
	typedef struct packed {
		kind_t            kind;
		logic [3:0][15:0] raw;
	} frame_t;

	function automatic type_dec_t decode_type(input logic [7:0] tb);
		type_dec_t d;
		d.known = 1'b1;
		d.kind  = KIND_ACC;
		case (tb)
			TYPE_ACC:   d.kind = KIND_ACC;
			TYPE_RATE:  d.kind = KIND_RATE;
			TYPE_ANGLE: d.kind = KIND_ANGLE;
			TYPE_QUAT:  d.kind = KIND_QUAT;
			default:    d.known = 1'b0;
		endcase
		return d;
	endfunction

	function automatic logic [11:0] kind_scale2(input kind_t k);
		logic [11:0] s;
		case (k)
			KIND_ACC:   s = SCALE2_ACC;
			KIND_RATE:  s = SCALE2_RATE;
			KIND_ANGLE: s = SCALE2_ANGLE;
			KIND_QUAT:  s = SCALE2_QUAT;
			default:    s = SCALE2_QUAT;
		endcase
		return s;
	endfunction

	function automatic logic signed [31:0] mul_scale(input logic signed [15:0] raw,
			input logic [11:0] sc2);
		logic signed [12:0] s;
		logic signed [28:0] p;
		s = $signed({1'b0, sc2});
		p = raw * s;
		return 32'(p);
	endfunction

endpackage

// ----- sv/imusfd_front.sv -----
// Front end: byte tracking, slot checks, payload capture and frame classification.
module imusfd_front import imusfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_ready,
	input  logic [7:0]   rx_byte,
	input  logic         buffer_start,
	input  logic [7:0]   buffer_length,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         queue_full,
	output logic         push,
	output frame_t       push_frame
);

	logic [7:0]        head_byte_q;
	logic [7:0]        min_length_q;
	logic              halted_q;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [7:0]        kind_q;
	logic [7:0]        payload_q [8];

	logic              accept;
	logic              eff_halt;
	logic [POS_W-1:0]  eff_pos;
	logic [SLOT_W-1:0] eff_slot;
	logic [8:0]        slot_end;
	logic              out_of_range;
	logic              active;
	type_dec_t         tdec;

	assign byte_ready = !queue_full;
	assign cfg_ready  = 1'b1;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		eff_halt     = buffer_start ? (buffer_length < min_length_q) : halted_q;
		eff_pos      = buffer_start ? '0 : pos_q;
		eff_slot     = buffer_start ? '0 : slot_q;
		slot_end     = 9'(eff_slot) * 9'(FRAME_BYTES) + 9'(FRAME_BYTES);
		out_of_range = (eff_slot >= SLOT_W'(MAX_FRAMES)) || (slot_end > {1'b0, buffer_length});
		active       = !eff_halt && !out_of_range;
		tdec         = decode_type(kind_q);
	end

	assign push = accept && active && (eff_pos == POS_W'(FRAME_BYTES - 1)) && tdec.known;

	always_comb begin
		push_frame.kind = tdec.kind;
		for (int i = 0; i < 4; i++) begin
			push_frame.raw[i] = {payload_q[2*i+1], payload_q[2*i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_byte_q  <= HEAD_RESET;
			min_length_q <= MIN_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEAD_BYTE:  head_byte_q  <= cfg_data;
				REG_MIN_LENGTH: min_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b1;
			pos_q    <= '0;
			slot_q   <= '0;
			kind_q   <= '0;
		end else if (accept) begin
			pos_q  <= eff_pos;
			slot_q <= eff_slot;
			if (eff_halt) begin
				halted_q <= 1'b1;
			end else if (out_of_range) begin
				halted_q <= 1'b1;
			end else begin
				halted_q <= 1'b0;
				if (eff_pos == POS_W'(FRAME_BYTES - 1)) begin
					pos_q  <= '0;
					slot_q <= eff_slot + 1'b1;
				end else begin
					pos_q <= eff_pos + 1'b1;
				end
				// wrong head drops the rest of the buffer
				if (eff_pos == '0 && rx_byte != head_byte_q) begin
					halted_q <= 1'b1;
				end
				if (eff_pos == POS_W'(1)) begin
					kind_q <= rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active && eff_pos >= POS_W'(2) && eff_pos <= POS_W'(9)) begin
			payload_q[3'(eff_pos - POS_W'(2))] <= rx_byte;
		end
	end

endmodule

// ----- sv/imusfd_queue.sv -----
// Short frame queue between the front end and the scaling back end.
module imusfd_queue import imusfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output frame_t head_frame
);

	frame_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty  = (count_q != '0);
	assign head_frame = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/imusfd_scale.sv -----
// Back end: scales queued raw values to Q15.16 into the output register.
module imusfd_scale import imusfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  not_empty,
	input  frame_t                head_frame,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser
);

	logic              valid_q;
	kind_t             kind_q;
	logic [3:0][31:0]  value_q;
	logic [11:0]       sc2;
	logic [3:0][31:0]  value_d;

	// load when the output register is empty or its beat leaves now
	assign pop = not_empty && (!valid_q || m_tready);

	always_comb begin
		sc2 = kind_scale2(head_frame.kind);
		for (int i = 0; i < 4; i++) begin
			value_d[i] = mul_scale($signed(head_frame.raw[i]), sc2);
		end
		if (head_frame.kind != KIND_QUAT) begin
			value_d[3] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head_frame.kind;
			value_q <= value_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {value_q[3], value_q[2], value_q[1], value_q[0]};
	assign m_tuser  = kind_q;

endmodule

// ----- sv/imu_serial_frame_decoder.sv -----
// Top level of the serial IMU frame decoder.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: rx_byte, buffer_length; tuser: buffer_start
//  m_*      out  m_tvalid/m_tready    tdata: value_x, value_y, value_z, value_w; tuser: frame_kind
//  cfg_*    in   cfg_valid/cfg_ready  index 0 head byte, 1 min_length; cfg_data
//
// One byte a cycle is taken while the frame queue is not full; a decoded frame
// is written into the queue at the edge that takes its last byte, and m_tvalid
// rises once the scaling register loads it from the queue head.
// The input stalls only while the four-entry frame queue is full.
// Reset leaves the decoder halted until a beat with buffer_start set, head 0x55
// and minimum length 33; configuration is always ready.
module imu_serial_frame_decoder import imusfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte, [15:8] buffer_length
	input  logic                  s_tuser,   // [0] buffer_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] value_x, [63:32] value_y,
	                                         // [95:64] value_z, [127:96] value_w
	output logic [1:0]            m_tuser,   // [1:0] frame_kind
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data
);

	logic   q_full;
	logic   q_push;
	frame_t q_push_frame;
	logic   q_pop;
	logic   q_not_empty;
	frame_t q_head;

	imusfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (s_tvalid),
		.byte_ready   (s_tready),
		.rx_byte      (s_tdata[7:0]),
		.buffer_start (s_tuser),
		.buffer_length(s_tdata[15:8]),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.queue_full   (q_full),
		.push         (q_push),
		.push_frame   (q_push_frame)
	);

	imusfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_frame(q_push_frame),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_frame(q_head)
	);

	imusfd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head_frame(q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
